### hdl/indexed_array_list_assert.svh
// indexed_array_list_assert.svh: assertion macros for the indexed array list checker
// depends on: nothing; included by the checker file
`ifndef INDEXED_ARRAY_LIST_ASSERT_SVH
`define INDEXED_ARRAY_LIST_ASSERT_SVH

// clocked assertion, masked while reset is active
`define IAL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define IAL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ial_pkg.sv
// ial_pkg: command codes, error codes and cell control type for the indexed array list
// depends on: nothing
package ial_pkg;

    typedef enum logic [2:0] {
        CMD_APPEND       = 3'd0,
        CMD_REMOVE_AT    = 3'd1,
        CMD_REMOVE_FIRST = 3'd2,
        CMD_REMOVE_LAST  = 3'd3,
        CMD_READ         = 3'd4,
        CMD_WRITE        = 3'd5
    } ial_cmd_t;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic wr;     // load wr_data into the cell at target
        logic shift;  // cells at or above target take their upper neighbor
    } ial_ctl_t;

endpackage

### hdl/ial_cell.sv
// ial_cell: one storage cell of the list, holds one word and takes its neighbor on a remove
// depends on: ial_pkg
module ial_cell #(
    parameter int IDX_W = 6
) (
    input  logic                 clk,
    input  logic [IDX_W-1:0]     index,
    input  logic [IDX_W-1:0]     target,
    input  ial_pkg::ial_ctl_t    ctl,
    input  logic [31:0]          wr_data,
    input  logic [31:0]          nbr_data,
    output logic [31:0]          data,
    output logic [31:0]          tap
);
    import ial_pkg::*;

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        hit;

    assign hit = (index == target);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.wr && hit)
        begin
            data_next = wr_data;
        end
        else if (ctl.shift && (index >= target))
        begin
            data_next = nbr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = hit ? data_reg : 32'd0;

endmodule

### hdl/indexed_array_list.sv
// indexed_array_list: ordered list of signed words kept in a row of register cells
// depends on: ial_pkg, ial_cell
//
// usage
//   the slave stream carries one command word per handshake, the master stream returns
//   exactly one result word per command, in order
//   s_tdata  : command [2:0], position [8:3], value [40:9], zero [47:41]
//   m_tdata  : data [31:0], error [33:32], element_count [40:34], zero [47:41]
//   commands : append, remove at index, remove first, remove last, read, write;
//   codes 6 and 7 are answered with the range error and change nothing
// timing
//   the result word is registered and appears in the cycle after its command is taken; one
//   command per cycle is sustained while results are taken, since every cell updates in parallel in that same cycle:
//   a write loads one cell, a remove makes every cell at or above the target take its
//   upper neighbor, and a read selects one cell through an and-or tree
// reset
//   rst_n clears the element count and the output valid; cell contents are left alone,
//   only cells below the count are ever read and each of them was written first
// backpressure
//   the result sits in an output register; while it is not taken s_tready drops, and
//   a new command is taken in the same cycle the pending result leaves
module indexed_array_list #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command[2:0], position[8:3], value[40:9], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // data[31:0], error[33:32], element_count[40:34], pad
);
    import ial_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
    localparam int OUT_W = (CNT_W > 7) ? CNT_W : 7;

    // input word fields
    ial_cmd_t    cmd;
    logic [5:0]  pos;
    logic [31:0] val;

    // state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [47:0]      m_tdata_reg;
    logic [47:0]      m_tdata_next;

    logic             accept;
    logic [CMP_W-1:0] pos_w;
    logic [CNT_W-1:0] count_dec;
    logic             pos_ok;
    logic             not_empty;
    logic             not_full;

    // command decode
    ial_ctl_t         ctl;
    ial_ctl_t         cell_ctl;
    logic [IDX_W-1:0] target;
    logic [1:0]       err;
    logic             rd;

    // cell row
    logic [31:0]      cell_data [DEPTH];
    logic [31:0]      cell_tap  [DEPTH];
    logic [31:0]      tap_or;
    logic [31:0]      data_out;
    logic [OUT_W-1:0] count_wide;

    assign cmd = ial_cmd_t'(s_tdata[2:0]);
    assign pos = s_tdata[8:3];
    assign val = s_tdata[40:9];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_w     = CMP_W'(pos);
    assign count_dec = count_reg - CNT_W'(1);
    assign pos_ok    = pos_w < CMP_W'(count_reg);
    assign not_empty = count_reg != '0;
    assign not_full  = count_reg != CNT_W'(DEPTH);

    always_comb
    begin
        ctl        = '0;
        target     = '0;
        err        = ERR_OK;
        rd         = 1'b0;
        count_next = count_reg;
        unique case (cmd)
            CMD_APPEND:
            begin
                if (not_full)
                begin
                    ctl.wr     = 1'b1;
                    target     = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    err = ERR_FULL;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (pos_ok)
                begin
                    ctl.shift  = 1'b1;
                    rd         = 1'b1;
                    target     = pos_w[IDX_W-1:0];
                    count_next = count_dec;
                end
                else
                begin
                    err = ERR_RANGE;
                end
            end
            CMD_REMOVE_FIRST:
            begin
                if (not_empty)
                begin
                    ctl.shift  = 1'b1;
                    rd         = 1'b1;
                    count_next = count_dec;
                end
                else
                begin
                    err = ERR_RANGE;
                end
            end
            CMD_REMOVE_LAST:
            begin
                if (not_empty)
                begin
                    ctl.shift  = 1'b1;
                    rd         = 1'b1;
                    target     = count_dec[IDX_W-1:0];
                    count_next = count_dec;
                end
                else
                begin
                    err = ERR_RANGE;
                end
            end
            CMD_READ:
            begin
                if (pos_ok)
                begin
                    rd     = 1'b1;
                    target = pos_w[IDX_W-1:0];
                end
                else
                begin
                    err = ERR_RANGE;
                end
            end
            CMD_WRITE:
            begin
                if (pos_ok)
                begin
                    ctl.wr = 1'b1;
                    target = pos_w[IDX_W-1:0];
                end
                else
                begin
                    err = ERR_RANGE;
                end
            end
            default:
            begin
                err = ERR_RANGE;
            end
        endcase
    end

    // cells only move on an accepted word
    assign cell_ctl = accept ? ctl : '0;

    // row of cells, each one takes its upper neighbor on a remove
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [31:0] nbr;
        if (i == DEPTH - 1)
        begin : g_top
            assign nbr = cell_data[i];
        end
        else
        begin : g_mid
            assign nbr = cell_data[i + 1];
        end

        ial_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .clk      (clk),
            .index    (IDX_W'(i)),
            .target   (target),
            .ctl      (cell_ctl),
            .wr_data  (val),
            .nbr_data (nbr),
            .data     (cell_data[i]),
            .tap      (cell_tap[i])
        );
    end

    // only the addressed cell drives a nonzero tap
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tap_or = tap_or | cell_tap[i];
        end
    end

    assign data_out   = rd ? tap_or : 32'd0;
    assign count_wide = OUT_W'(count_next);

    assign m_tvalid_next = accept ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    assign m_tdata_next  = accept ? {7'd0, count_wide[6:0], err, data_out} : m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hdl/ial_checker.sv
// ial_checker: port-level assertions for indexed_array_list, bound to the top level
// depends on: ial_pkg, indexed_array_list_assert.svh
`include "indexed_array_list_assert.svh"

module ial_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import ial_pkg::*;

    // a stalled result holds its word
    `IAL_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed under stall")

    // each taken command gives a result in the next cycle
    `IAL_ASSERT(a_latency, s_tvalid && s_tready |=> m_tvalid, "no result after accepted command")

    // an empty output register never blocks input
    `IAL_ASSERT(a_ready, !m_tvalid |-> s_tready, "input blocked with empty output")

    // errors carry zero data
    `IAL_ASSERT(a_err_data, m_tvalid && (m_tdata[33:32] != ERR_OK) |-> m_tdata[31:0] == 32'd0, "nonzero data on error")

    // only defined error codes
    `IAL_ASSERT(a_err_code, m_tvalid |-> m_tdata[33:32] != 2'd3, "undefined error code")

endmodule

bind indexed_array_list ial_checker u_ial_checker (.*);

### sim/ial_list_checker.sv
// ial_list_checker: watches both streams of the indexed array list, keeps its own copy of
// the list, predicts each reply word and compares it field by field
// depends on: ial_pkg
`timescale 1ns / 1ps

module ial_list_checker #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // command[2:0], position[8:3], value[40:9], pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // data[31:0], error[33:32], element_count[40:34], pad
    output int          fail_count,
    output int          pending
);
    import ial_pkg::*;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         error;
        logic [6:0]         element_count;
    } list_reply_t;

    logic signed [31:0] list_words [DEPTH];
    int                 list_len = 0;
    list_reply_t        reply_q [$];
    int                 bad_words = 0;
    int                 reply_index = 0;

    // take out one word and close the gap above it
    function automatic logic signed [31:0] pull_word(input int idx);
        logic signed [31:0] taken;
        taken = list_words[idx];
        for (int i = idx; i + 1 < list_len; i++)
            list_words[i] = list_words[i + 1];
        list_len--;
        return taken;
    endfunction

    function automatic list_reply_t apply_command(input logic [2:0] cmd,
                                                  input logic [5:0] pos,
                                                  input logic signed [31:0] val);
        list_reply_t res;
        res       = '0;
        res.error = ERR_OK;
        case (ial_cmd_t'(cmd))
            CMD_APPEND:
                if (list_len >= DEPTH)
                    res.error = ERR_FULL;
                else
                begin
                    list_words[list_len] = val;
                    list_len++;
                end
            CMD_REMOVE_AT:
                if (int'(pos) < list_len)
                    res.data = pull_word(int'(pos));
                else
                    res.error = ERR_RANGE;
            CMD_REMOVE_FIRST:
                if (list_len > 0)
                    res.data = pull_word(0);
                else
                    res.error = ERR_RANGE;
            CMD_REMOVE_LAST:
                if (list_len > 0)
                    res.data = pull_word(list_len - 1);
                else
                    res.error = ERR_RANGE;
            CMD_READ:
                if (int'(pos) < list_len)
                    res.data = list_words[pos];
                else
                    res.error = ERR_RANGE;
            CMD_WRITE:
                if (int'(pos) < list_len)
                    list_words[pos] = val;
                else
                    res.error = ERR_RANGE;
            default:
                res.error = ERR_RANGE;
        endcase
        res.element_count = 7'(list_len);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t got;
        list_reply_t want;
        if (!rst_n)
        begin
            list_len    = 0;
            bad_words   = 0;
            reply_index = 0;
            reply_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // a reply leaving now belongs to an older command, so pop before push
            if (m_tvalid && m_tready)
            begin
                got.data          = m_tdata[31:0];
                got.error         = m_tdata[33:32];
                got.element_count = m_tdata[40:34];
                if (reply_q.size() == 0)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("reply word %0d arrived with nothing expected", reply_index);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got.data !== want.data || got.error !== want.error ||
                        got.element_count !== want.element_count)
                    begin
                        bad_words++;
                        if (bad_words <= 10)
                        begin
                            $write("reply word %0d: expected data %0d error %0d count %0d,",
                                   reply_index, want.data, want.error, want.element_count);
                            $display(" got data %0d error %0d count %0d",
                                     got.data, got.error, got.element_count);
                        end
                    end
                end
                reply_index++;
            end
            if (s_tvalid && s_tready)
                reply_q.push_back(apply_command(s_tdata[2:0], s_tdata[8:3], s_tdata[40:9]));
            fail_count <= bad_words;
            pending    <= reply_q.size();
        end
    end

endmodule

### sim/tb_indexed_array_list.sv
// tb_indexed_array_list: drives command words into the indexed array list and gives the verdict
// depends on: ial_pkg, indexed_array_list, ial_list_checker
`timescale 1ns / 1ps

module tb_indexed_array_list;
    import ial_pkg::*;

    localparam int DEPTH           = 64;
    localparam int RX_HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block
    localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no word moving on either side
    localparam int PHASE_WORDS     = 600;

    // command codes the package leaves unnamed; the block answers them with a range error
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // command[2:0], position[8:3], value[40:9], pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // data[31:0], error[33:32], element_count[40:34], pad

    int fail_count;
    int pending;

    // stimulus-side settings and counters, read by the sender, the receiver and the watchdog
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int holds_asked   = 0;
    int holds_granted = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    // rough length of the list, only used to aim positions at live entries
    int shadow_len = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    indexed_array_list #(
        .DEPTH(DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    ial_list_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_granted != holds_asked)
        begin
            m_tready      <= 1'b0;
            holds_granted <= holds_granted + 1;
            hold_left     <= RX_HOLD_CYCLES;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog: a stuck handshake on either side ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one command word, with random sender gaps in front of it
    task automatic send_word(input logic [2:0] cmd, input logic [5:0] pos,
                             input logic signed [31:0] val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, val, pos, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        // keep the length estimate in step with what the block will do
        case (cmd)
            CMD_APPEND:
                if (shadow_len < DEPTH)
                    shadow_len++;
            CMD_REMOVE_AT:
                if (int'(pos) < shadow_len)
                    shadow_len--;
            CMD_REMOVE_FIRST, CMD_REMOVE_LAST:
                if (shadow_len > 0)
                    shadow_len--;
            default:
                ;
        endcase
    endtask

    // sender pauses until every reply word is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // one random command; grow_pct steers the list toward full or toward empty
    task automatic random_word(input int grow_pct);
        logic [2:0]         cmd;
        logic [5:0]         pos;
        logic signed [31:0] val;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < grow_pct)
            cmd = CMD_APPEND;
        else
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                cmd = CMD_REMOVE_AT;
            else if (pick < 25)
                cmd = CMD_REMOVE_FIRST;
            else if (pick < 35)
                cmd = CMD_REMOVE_LAST;
            else if (pick < 65)
                cmd = CMD_READ;
            else if (pick < 95)
                cmd = CMD_WRITE;
            else
                cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        end
        // mostly live positions, sometimes anything the field holds
        if (shadow_len > 0 && $urandom_range(9) != 0)
            pos = 6'($urandom_range(shadow_len - 1));
        else
            pos = 6'($urandom_range(63));
        case ($urandom_range(15))
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2:       val = '0;
            3:       val = '1;
            default: val = $urandom;
        endcase
        send_word(cmd, pos, val);
    endtask

    // one idling setting: random words, bias cycling every 50 words, one long receiver hold
    task automatic run_phase(input int tx_pct, input int rx_pct);
        int grow;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        for (int i = 0; i < PHASE_WORDS; i++)
        begin
            case ((i / 50) % 3)
                0:       grow = 75;
                1:       grow = 45;
                default: grow = 15;
            endcase
            if (i == PHASE_WORDS / 2)
                holds_asked <= holds_asked + 1;
            random_word(grow);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 26;
        rx_idle_pct <= 71;

        // empty list: every access and every remove is out of range
        send_word(CMD_READ,         6'd0,  32'sd0);
        send_word(CMD_REMOVE_FIRST, 6'd0,  32'sd0);
        send_word(CMD_REMOVE_LAST,  6'd0,  32'sd0);
        send_word(CMD_REMOVE_AT,    6'd0,  32'sd0);
        send_word(CMD_WRITE,        6'd0,  32'sd5);
        // value extremes
        send_word(CMD_APPEND,       6'd0,  32'h7FFF_FFFF);
        send_word(CMD_APPEND,       6'd0,  32'h8000_0000);
        send_word(CMD_APPEND,       6'd0,  32'h0000_0000);
        send_word(CMD_APPEND,       6'd0,  32'hFFFF_FFFF);
        // reads inside, at the count, and at the largest position
        send_word(CMD_READ,         6'd0,  32'sd0);
        send_word(CMD_READ,         6'd3,  32'sd0);
        send_word(CMD_READ,         6'd4,  32'sd0);
        send_word(CMD_READ,         6'd63, 32'sd0);
        send_word(CMD_WRITE,        6'd1,  32'h5555_5555);
        send_word(CMD_WRITE,        6'd63, 32'h1234_5678);
        // remove from the middle, then past the end, then both ends
        send_word(CMD_REMOVE_AT,    6'd1,  32'sd0);
        send_word(CMD_REMOVE_AT,    6'd3,  32'sd0);
        send_word(CMD_REMOVE_FIRST, 6'd0,  32'sd0);
        send_word(CMD_REMOVE_LAST,  6'd0,  32'sd0);
        // spare codes change nothing
        send_word(CMD_SPARE_LO,     6'd0,  32'sd0);
        send_word(CMD_SPARE_HI,     6'd63, 32'hFFFF_FFFF);
        send_word(CMD_READ,         6'd0,  32'sd0);
        send_word(CMD_WRITE,        6'd0,  32'hAAAA_AAAA);
        send_word(CMD_REMOVE_AT,    6'd0,  32'sd0);

        // fill to capacity and two past it, touch the top entry, then drain to empty
        while (shadow_len < DEPTH)
            send_word(CMD_APPEND, 6'($urandom_range(63)), $urandom);
        send_word(CMD_APPEND,    6'd0,  $urandom);
        send_word(CMD_APPEND,    6'd0,  $urandom);
        send_word(CMD_READ,      6'd63, 32'sd0);
        send_word(CMD_WRITE,     6'd63, $urandom);
        send_word(CMD_REMOVE_AT, 6'd63, 32'sd0);
        send_word(CMD_REMOVE_AT, 6'd0,  32'sd0);
        send_word(CMD_REMOVE_LAST, 6'd0, 32'sd0);
        while (shadow_len > 0)
            send_word(CMD_REMOVE_FIRST, 6'($urandom_range(63)), $urandom);
        send_word(CMD_REMOVE_FIRST, 6'd0, 32'sd0);
        wait_drained();

        // receiver idles more, then sender idles more, then back to back
        run_phase(26, 71);
        run_phase(71, 26);
        run_phase(0, 0);

        // wait out the last reply and any stray words
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/ial_pkg.sv
hdl/ial_cell.sv
hdl/indexed_array_list.sv
hdl/ial_checker.sv
sim/ial_list_checker.sv
sim/tb_indexed_array_list.sv
